>>> src/dea_pkg.sv
// Shared types, codes and constants of the double-ended arena allocator.
`default_nettype none
package dea_pkg;

  // Mark stack geometry
  localparam int MARK_DEPTH = 8;
  localparam int MARK_IDX_W = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int MARK_CNT_W = $clog2(MARK_DEPTH + 1);

  // Alignment is a power of two: ALIGN_BYTES = 2**ALIGN_LG
  localparam int ALIGN_LG    = 2;
  localparam int ALIGN_BYTES = 1 << ALIGN_LG;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 24;
  localparam int RSIZE_W = SIZE_W + 1;
  localparam int ID_W    = 3;
  localparam int MODE_W  = 4;
  localparam int IDX_W   = 4;
  localparam int FREE_W  = 25;

  // Configuration port
  localparam int REG_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESET    = 4'd0,
    MODE_ALLOC_LO = 4'd1,
    MODE_ALLOC_HI = 4'd2,
    MODE_REALLOC  = 4'd3,
    MODE_CLR_HI   = 4'd4,
    MODE_PUSH     = 4'd5,
    MODE_POP      = 4'd6,
    MODE_POP_TO   = 4'd7,
    MODE_CLR_LO   = 4'd8,
    MODE_QUERY    = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    REG_PACK_BASE  = 2'd0,
    REG_PACK_SIZE  = 2'd1,
    REG_HIGH_RESET = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FREE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] pack_base;
    logic [SIZE_W-1:0] pack_size;
    logic [ADDR_W-1:0] high_reset_addr;
  } cfg_t;

  typedef struct packed {
    logic capture;   // latch request, read mark entry
    logic exec;      // update arena state, latch address/error
    logic load_out;  // load result register
  } cmd_t;

endpackage
`default_nettype wire

>>> src/dea_regs.sv
// APB configuration registers of the arena allocator.
`default_nettype none
module dea_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dea_pkg::REG_ADDR_W-1:0]   paddr,
  input  wire logic [dea_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [dea_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output dea_pkg::cfg_t                         cfg_o
);

  dea_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        dea_pkg::REG_PACK_BASE:  cfg_d.pack_base       = pwdata;
        dea_pkg::REG_PACK_SIZE:  cfg_d.pack_size       = pwdata[dea_pkg::SIZE_W-1:0];
        dea_pkg::REG_HIGH_RESET: cfg_d.high_reset_addr = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dea_pkg::REG_PACK_BASE:  prdata = cfg_q.pack_base;
      dea_pkg::REG_PACK_SIZE:  prdata = {8'd0, cfg_q.pack_size};
      dea_pkg::REG_HIGH_RESET: prdata = cfg_q.high_reset_addr;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> src/dea_ctrl.sv
// Sequencer of the arena allocator: capture, execute, result load.
`default_nettype none
module dea_ctrl (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output dea_pkg::cmd_t cmd_o
);

  dea_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dea_pkg::ST_IDLE: if (in_valid_i) state_d = dea_pkg::ST_EXEC;
      dea_pkg::ST_EXEC: state_d = dea_pkg::ST_FREE;
      dea_pkg::ST_FREE: if (out_free) state_d = dea_pkg::ST_IDLE;
      default:          state_d = dea_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      dea_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      dea_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      dea_pkg::ST_FREE: cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dea_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

>>> src/dea_dpath.sv
// Arena pointers, mark stack memory and result register of the allocator.
`default_nettype none
module dea_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire dea_pkg::cmd_t                  cmd_i,
  input  wire dea_pkg::cfg_t                  cfg_i,
  input  wire logic [dea_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [dea_pkg::SIZE_W-1:0]     alloc_size_i,
  input  wire logic [dea_pkg::ID_W-1:0]       mark_id_i,
  output logic      [dea_pkg::ADDR_W-1:0]     address_o,
  output logic      [dea_pkg::IDX_W-1:0]      mark_index_o,
  output logic      [dea_pkg::FREE_W-1:0]     free_bytes_o,
  output logic                                error_o
);

  localparam int AW = dea_pkg::ADDR_W;
  localparam int RW = dea_pkg::RSIZE_W;
  localparam int CW = dea_pkg::MARK_CNT_W;
  localparam int IW = dea_pkg::MARK_IDX_W;

  // Request latch
  logic [dea_pkg::MODE_W-1:0] mode_q;
  logic [dea_pkg::SIZE_W-1:0] size_q;
  logic [dea_pkg::ID_W-1:0]   id_q;
  logic [AW-1:0]              mark_rd_q;

  // Arena state
  logic [AW-1:0] low_q, low_d, high_q, high_d;
  logic [RW-1:0] last_q, last_d;
  logic [CW-1:0] count_q, count_d;

  // Step result before the free count is added
  logic [AW-1:0]              addr_q, addr_d;
  logic                       err_q, err_d;
  logic [dea_pkg::IDX_W-1:0]  idx_q;

  // Result register
  logic [AW-1:0]               out_addr_q;
  logic [dea_pkg::IDX_W-1:0]   out_idx_q;
  logic [dea_pkg::FREE_W-1:0]  out_free_q, free_sat;
  logic                        out_err_q;

  logic [AW-1:0] mark_mem [dea_pkg::MARK_DEPTH];
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] count_dec;
  logic          push_ok;

  logic [AW-1:0] free_now, free_new;
  logic          fits;
  logic [RW-1:0] rnd;

  // Mark read address: top of stack for pop, the named mark otherwise
  assign count_dec = count_q - CW'(1);
  assign rd_addr   = (mode_i == dea_pkg::MODE_POP) ? count_dec[IW-1:0] : IW'(mark_id_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q    <= mode_i;
      size_q    <= alloc_size_i;
      id_q      <= mark_id_i;
      mark_rd_q <= mark_mem[rd_addr];
    end
    if (cmd_i.exec && push_ok) begin
      mark_mem[count_q[IW-1:0]] <= low_q;
    end
  end

  assign free_now = high_q - low_q;
  assign fits     = !($signed(free_now) < $signed({8'd0, size_q}));
  assign rnd      = ({1'b0, size_q} + RW'(dea_pkg::ALIGN_BYTES - 1))
                    & ~RW'(dea_pkg::ALIGN_BYTES - 1);
  assign push_ok  = (mode_q == dea_pkg::MODE_PUSH) && (count_q < CW'(dea_pkg::MARK_DEPTH));

  always_comb begin
    low_d   = low_q;
    high_d  = high_q;
    last_d  = last_q;
    count_d = count_q;
    err_d   = 1'b0;
    addr_d  = low_q;
    case (mode_q)
      dea_pkg::MODE_RESET: begin
        low_d   = cfg_i.pack_base;
        high_d  = cfg_i.pack_base + AW'(cfg_i.pack_size);
        count_d = '0;
        addr_d  = cfg_i.pack_base;
      end
      dea_pkg::MODE_ALLOC_LO: begin
        if (fits) begin
          last_d = rnd;
          low_d  = low_q + AW'(rnd);
        end else begin
          err_d  = 1'b1;
        end
      end
      dea_pkg::MODE_ALLOC_HI: begin
        if (fits) begin
          last_d = rnd;
          high_d = high_q - AW'(rnd);
          addr_d = high_d;
        end else begin
          err_d  = 1'b1;
        end
      end
      dea_pkg::MODE_REALLOC: begin
        low_d  = low_q - AW'(last_q) + AW'(rnd);
        last_d = rnd;
        addr_d = low_d;
      end
      dea_pkg::MODE_CLR_HI: high_d = cfg_i.high_reset_addr;
      dea_pkg::MODE_PUSH: begin
        if (push_ok) count_d = count_q + CW'(1);
        else         err_d   = 1'b1;
      end
      dea_pkg::MODE_POP: begin
        if (count_q != '0) begin
          count_d = count_dec;
          low_d   = mark_rd_q;
          addr_d  = mark_rd_q;
        end else begin
          err_d   = 1'b1;
        end
      end
      dea_pkg::MODE_POP_TO: begin
        if (CW'(id_q) < count_q) begin
          count_d = CW'(id_q);
          low_d   = mark_rd_q;
          addr_d  = mark_rd_q;
        end else begin
          err_d   = 1'b1;
        end
      end
      dea_pkg::MODE_CLR_LO: begin
        count_d = '0;
        low_d   = cfg_i.pack_base;
        addr_d  = cfg_i.pack_base;
      end
      default: ;
    endcase
    if (err_d) begin
      low_d   = low_q;
      high_d  = high_q;
      last_d  = last_q;
      count_d = count_q;
      addr_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= '0;
      high_q  <= '0;
      last_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      low_q   <= low_d;
      high_q  <= high_d;
      last_q  <= last_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      addr_q <= addr_d;
      err_q  <= err_d;
      idx_q  <= dea_pkg::IDX_W'(count_q);
    end
  end

  // Saturate the signed distance between the pointers to the 25-bit range
  assign free_new = high_q - low_q;
  always_comb begin
    if (!free_new[AW-1] && (free_new[AW-1:dea_pkg::FREE_W-1] != '0)) begin
      free_sat = {1'b0, {(dea_pkg::FREE_W-1){1'b1}}};
    end else if (free_new[AW-1] && (free_new[AW-1:dea_pkg::FREE_W-1] != '1)) begin
      free_sat = {1'b1, {(dea_pkg::FREE_W-1){1'b0}}};
    end else begin
      free_sat = free_new[dea_pkg::FREE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_addr_q <= addr_q;
      out_idx_q  <= idx_q;
      out_free_q <= free_sat;
      out_err_q  <= err_q;
    end
  end

  assign address_o    = out_addr_q;
  assign mark_index_o = out_idx_q;
  assign free_bytes_o = out_free_q;
  assign error_o      = out_err_q;

endmodule
`default_nettype wire

>>> src/double_ended_arena_allocator_core.sv
// Top level of the double-ended arena allocator with a mark stack.
//
// Each request item carries a mode (reset arena, allocate low, allocate high,
// resize last allocation, clear high end, push mark, pop mark, pop to mark,
// clear low end, query; unused codes act as query) and gives exactly one
// result item: an address, the mark count before the step, the signed free
// byte count after the step (saturated to 25 bits) and an error flag. A
// refused request (too little space, full or empty mark stack, bad mark id)
// returns address 0 with error set and leaves every pointer and the mark
// stack untouched. Sizes are rounded up to ALIGN_BYTES; the space check uses
// the unrounded size. An item goes through capture, execute and result load:
// capture latches the request and reads the mark memory, execute checks
// and updates the arena pointers, and result load computes the free count
// into the result register. The next item is accepted once the result
// register has been loaded, so a new request is not taken before the
// previous one is through; a stalled result holds the sequencer in its last
// step until the register frees up. Configuration registers sit on an APB
// port at byte addresses 0 (pack_base), 4 (pack_size) and 8 (high_reset_addr)
// and must only be written while no request is in flight. Mark entries that
// were never pushed hold unknown data; valid pops never read them.
`default_nettype none
module double_ended_arena_allocator_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [31:0]                     s_axis_tdata,  // alloc_size[23:0], mark_id[26:24]
  input  wire logic [3:0]                      s_axis_tuser,  // mode[3:0]
  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [63:0]                     m_axis_tdata,  // address[31:0], mark_index[35:32],
                                                              // free_bytes[60:36]
  output logic      [0:0]                      m_axis_tuser,  // error[0]
  // Configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dea_pkg::REG_ADDR_W-1:0]  paddr,
  input  wire logic [dea_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [dea_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  dea_pkg::cfg_t cfg;
  dea_pkg::cmd_t cmd;

  logic [dea_pkg::ADDR_W-1:0] address;
  logic [dea_pkg::IDX_W-1:0]  mark_index;
  logic [dea_pkg::FREE_W-1:0] free_bytes;
  logic                       error;

  dea_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: one item in flight, result register decoupled from the output
  dea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  dea_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .mode_i       (s_axis_tuser),
    .alloc_size_i (s_axis_tdata[23:0]),
    .mark_id_i    (s_axis_tdata[26:24]),
    .address_o    (address),
    .mark_index_o (mark_index),
    .free_bytes_o (free_bytes),
    .error_o      (error)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {3'd0, free_bytes, mark_index, address};
  assign m_axis_tuser = error;

  // One request at a time: the port closes right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // A refused request always reports address zero
  a_err_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("error result with nonzero address");

  // Reported mark count never exceeds the stack depth
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[35:32] <= 4'(dea_pkg::MARK_DEPTH))
    else $error("mark count beyond stack depth");

  // A result becomes valid only after a command sequence, never from idle
  a_out_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

endmodule
`default_nettype wire
